// File: rtl/heightmap_to_triangle_mesh_core_assert.svh
// assertion macros for the heightmap mesh core
// used by the top level only, needs clk and rst_n in scope
`ifndef HEIGHTMAP_TO_TRIANGLE_MESH_CORE_ASSERT_SVH
`define HEIGHTMAP_TO_TRIANGLE_MESH_CORE_ASSERT_SVH

// implication checked on every clock edge after reset
`define HMTM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define HMTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hmtm_pkg.sv
// shared constants, register codes and control structs of the mesh core
// no dependencies
`default_nettype none
package hmtm_pkg;
  localparam int unsigned MAX_WIDTH_DEF = 4096;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned DEPTH_W = 23;
  localparam int unsigned ODEPTH_W = 22;
  localparam int unsigned COORD_W = 24;
  localparam int unsigned NORM_W = 32;
  localparam int unsigned DIM_W = 13;
  localparam int unsigned GAIN_W = 20;
  localparam int unsigned GAIN_FRAC = 24;
  localparam int unsigned SUM_W = 10;
  localparam int unsigned ROW_W = 12;
  localparam int unsigned DIFF_W = DEPTH_W + 1;
  localparam int unsigned PROD_W = DIFF_W + COORD_W + 1;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_XSTEP   = 3'd2,
    REG_YSTEP   = 3'd3,
    REG_PHEIGHT = 3'd4,
    REG_GAIN    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [COORD_W-1:0] x_step;
    logic [COORD_W-1:0] y_step;
    logic [COORD_W-1:0] print_height;
    logic [GAIN_W-1:0]  depth_gain;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic gain;
    logic depth;
    logic commit;
    logic mul;
    logic load1;
    logic load2;
  } dp_cmd_t;

  typedef struct packed {
    logic interior;
    logic out_free;
  } dp_stat_t;
endpackage
`default_nettype wire

// File: rtl/hmtm_if.sv
// pixel and triangle channel interfaces
// depends on hmtm_pkg for field widths
`default_nettype none
interface hmtm_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source(output valid, output red, output green, output blue, input ready);
  modport sink(input valid, input red, input green, input blue, output ready);
endinterface

interface hmtm_tri_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [hmtm_pkg::NORM_W-1:0]     normal_x;
  logic signed [hmtm_pkg::NORM_W-1:0]     normal_y;
  logic signed [hmtm_pkg::NORM_W-1:0]     normal_z;
  logic [hmtm_pkg::COORD_W-1:0]           first_x;
  logic [hmtm_pkg::COORD_W-1:0]           second_x;
  logic [hmtm_pkg::COORD_W-1:0]           shared_y;
  logic [hmtm_pkg::COORD_W-1:0]           third_y;
  logic signed [hmtm_pkg::ODEPTH_W-1:0]   first_depth;
  logic signed [hmtm_pkg::ODEPTH_W-1:0]   second_depth;
  logic signed [hmtm_pkg::ODEPTH_W-1:0]   third_depth;
  logic                                   last_of_pixel;
  modport source(output valid, output normal_x, output normal_y, output normal_z,
                 output first_x, output second_x, output shared_y, output third_y,
                 output first_depth, output second_depth, output third_depth,
                 output last_of_pixel, input ready);
  modport sink(input valid, input normal_x, input normal_y, input normal_z,
               input first_x, input second_x, input shared_y, input third_y,
               input first_depth, input second_depth, input third_depth,
               input last_of_pixel, output ready);
endinterface
`default_nettype wire

// File: rtl/hmtm_regs.sv
// apb configuration register file
// depends on hmtm_pkg
`default_nettype none
module hmtm_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hmtm_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [hmtm_pkg::DATA_W-1:0]   pwdata,
  output logic      [hmtm_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output hmtm_pkg::cfg_t                     cfg
);
  hmtm_pkg::cfg_t     cfg_r;
  hmtm_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = hmtm_pkg::reg_idx_t'(paddr[hmtm_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= hmtm_pkg::DIM_W'(2);
      cfg_r.image_height <= hmtm_pkg::DIM_W'(2);
      cfg_r.x_step       <= hmtm_pkg::COORD_W'(65536);
      cfg_r.y_step       <= hmtm_pkg::COORD_W'(65536);
      cfg_r.print_height <= hmtm_pkg::COORD_W'(65536);
      cfg_r.depth_gain   <= '0;
    end else if (wr) begin
      unique case (idx)
        hmtm_pkg::REG_WIDTH:   cfg_r.image_width  <= pwdata[hmtm_pkg::DIM_W-1:0];
        hmtm_pkg::REG_HEIGHT:  cfg_r.image_height <= pwdata[hmtm_pkg::DIM_W-1:0];
        hmtm_pkg::REG_XSTEP:   cfg_r.x_step       <= pwdata[hmtm_pkg::COORD_W-1:0];
        hmtm_pkg::REG_YSTEP:   cfg_r.y_step       <= pwdata[hmtm_pkg::COORD_W-1:0];
        hmtm_pkg::REG_PHEIGHT: cfg_r.print_height <= pwdata[hmtm_pkg::COORD_W-1:0];
        hmtm_pkg::REG_GAIN:    cfg_r.depth_gain   <= pwdata[hmtm_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      hmtm_pkg::REG_WIDTH:   prdata = hmtm_pkg::DATA_W'(cfg_r.image_width);
      hmtm_pkg::REG_HEIGHT:  prdata = hmtm_pkg::DATA_W'(cfg_r.image_height);
      hmtm_pkg::REG_XSTEP:   prdata = hmtm_pkg::DATA_W'(cfg_r.x_step);
      hmtm_pkg::REG_YSTEP:   prdata = hmtm_pkg::DATA_W'(cfg_r.y_step);
      hmtm_pkg::REG_PHEIGHT: prdata = hmtm_pkg::DATA_W'(cfg_r.print_height);
      hmtm_pkg::REG_GAIN:    prdata = hmtm_pkg::DATA_W'(cfg_r.depth_gain);
      default:               prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/hmtm_ctrl.sv
// sequencer for one pixel: gain, depth, line buffer update, and for interior pixels products and two triangles
// depends on hmtm_pkg
`default_nettype none
module hmtm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire hmtm_pkg::dp_stat_t  stat,
  output hmtm_pkg::dp_cmd_t        cmd
);
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_GAIN   = 7'b0000010,
    S_DEPTH  = 7'b0000100,
    S_COMMIT = 7'b0001000,
    S_MUL    = 7'b0010000,
    S_EMIT1  = 7'b0100000,
    S_EMIT2  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = S_DEPTH;
      end
      S_DEPTH: begin
        cmd.depth = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = stat.interior ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_EMIT1;
      end
      S_EMIT1: begin
        if (stat.out_free) begin
          cmd.load1 = 1'b1;
          state_nxt = S_EMIT2;
        end
      end
      S_EMIT2: begin
        if (stat.out_free) begin
          cmd.load2 = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

// File: rtl/hmtm_dp.sv
// datapath: depth, line buffer, position counters, normal products, output register
// depends on hmtm_pkg and hmtm_if
`default_nettype none
module hmtm_dp #(
  parameter int unsigned MAX_WIDTH = hmtm_pkg::MAX_WIDTH_DEF,
  parameter int unsigned FRAC_BITS = hmtm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire hmtm_pkg::cfg_t      cfg,
  input  wire hmtm_pkg::dp_cmd_t   cmd,
  output hmtm_pkg::dp_stat_t       stat,
  input  wire logic [7:0]          red,
  input  wire logic [7:0]          green,
  input  wire logic [7:0]          blue,
  hmtm_tri_if.source               out_tri
);
  localparam int unsigned CW     = $clog2(MAX_WIDTH);
  localparam int unsigned XM_W   = CW + hmtm_pkg::COORD_W;
  localparam int unsigned YM_W   = hmtm_pkg::ROW_W + hmtm_pkg::COORD_W;
  localparam int unsigned GP_W   = hmtm_pkg::GAIN_W + hmtm_pkg::SUM_W;
  localparam int unsigned DW     = hmtm_pkg::DEPTH_W;
  localparam int unsigned OW     = hmtm_pkg::ODEPTH_W;
  localparam int unsigned PW     = hmtm_pkg::PROD_W;
  localparam int unsigned QW     = hmtm_pkg::COORD_W;

  // line buffer of the previous row, contents undefined until written
  logic [DW-1:0] row_mem [MAX_WIDTH];

  logic [CW-1:0]                  col_r, pos_c_r;
  logic [hmtm_pkg::ROW_W-1:0]     row_r, pos_r_r;
  logic [hmtm_pkg::SUM_W-1:0]     sum_r;
  logic [GP_W-1:0]                gprod_r;
  logic [DW-1:0]                  up_r, cur_r, left_r, ul_r;
  logic [OW-1:0]                  o_up_r, o_ul_r, o_left_r, o_cur_r;
  logic signed [hmtm_pkg::DIFF_W-1:0] da_r, db_r, dc_r, dd_r;
  logic signed [PW-1:0]           pa_r, pb_r, pc_r, pd_r, pxy_r;
  logic [QW-1:0]                  xc_r, yc_r;
  logic                           ov_r;

  logic [31:0]                    raw;
  logic signed [hmtm_pkg::DIFF_W-1:0] up_s, ul_s, left_s, cur_s;
  logic signed [QW:0]             xs_s, ys_s;
  logic [XM_W-1:0]                xm;
  logic [YM_W-1:0]                ym;
  logic [QW-1:0]                  xl, yu;
  logic [31:0]                    w_sat, h_sat, c_inc, r_inc;
  logic [CW-1:0]                  col_nxt;
  logic [hmtm_pkg::ROW_W-1:0]     row_nxt;

  function automatic logic [hmtm_pkg::NORM_W-1:0] scale(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v >>> FRAC_BITS;
    return t[hmtm_pkg::NORM_W-1:0];
  endfunction

  assign raw = 32'(1 << (FRAC_BITS - 3)) - 32'(gprod_r >> (hmtm_pkg::GAIN_FRAC - FRAC_BITS));

  assign up_s   = hmtm_pkg::DIFF_W'(signed'(up_r));
  assign ul_s   = hmtm_pkg::DIFF_W'(signed'(ul_r));
  assign left_s = hmtm_pkg::DIFF_W'(signed'(left_r));
  assign cur_s  = hmtm_pkg::DIFF_W'(signed'(cur_r));
  assign xs_s   = signed'({1'b0, cfg.x_step});
  assign ys_s   = signed'({1'b0, cfg.y_step});

  assign xm = XM_W'(pos_c_r) * XM_W'(cfg.x_step);
  assign ym = YM_W'(pos_r_r) * YM_W'(cfg.y_step);
  assign xl = xc_r - cfg.x_step;
  assign yu = yc_r + cfg.y_step;

  // saturated frame size and next pixel position
  always_comb begin
    w_sat = 32'(cfg.image_width);
    if (w_sat < 32'd2) w_sat = 32'd2;
    if (w_sat > 32'(MAX_WIDTH)) w_sat = 32'(MAX_WIDTH);
    h_sat = 32'(cfg.image_height);
    if (h_sat < 32'd2) h_sat = 32'd2;
    if (h_sat > 32'(hmtm_pkg::MAX_HEIGHT)) h_sat = 32'(hmtm_pkg::MAX_HEIGHT);
    c_inc   = 32'(col_r) + 32'd1;
    r_inc   = 32'(row_r) + 32'd1;
    col_nxt = c_inc[CW-1:0];
    row_nxt = row_r;
    if (c_inc >= w_sat) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h_sat) ? '0 : r_inc[hmtm_pkg::ROW_W-1:0];
    end
  end

  assign stat.interior = (pos_c_r != '0) && (pos_r_r != '0);
  assign stat.out_free = !ov_r || out_tri.ready;

  // line buffer port: read at accept, write at commit
  always_ff @(posedge clk) begin
    if (cmd.accept) up_r <= row_mem[col_r];
    if (cmd.commit) row_mem[pos_c_r] <= cur_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
      ul_r   <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        left_r <= cur_r;
        ul_r   <= up_r;
      end
      if (cmd.load1 || cmd.load2) ov_r <= 1'b1;
      else if (out_tri.ready)     ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum_r   <= hmtm_pkg::SUM_W'(red) + hmtm_pkg::SUM_W'(green) + hmtm_pkg::SUM_W'(blue);
      pos_c_r <= col_r;
      pos_r_r <= row_r;
    end
    if (cmd.gain)  gprod_r <= GP_W'(cfg.depth_gain) * GP_W'(sum_r);
    if (cmd.depth) cur_r   <= raw[DW-1:0];
    if (cmd.commit) begin
      da_r     <= up_s - ul_s;
      db_r     <= left_s - ul_s;
      dc_r     <= left_s - cur_s;
      dd_r     <= up_s - cur_s;
      o_up_r   <= up_r[OW-1:0];
      o_ul_r   <= ul_r[OW-1:0];
      o_left_r <= left_r[OW-1:0];
      o_cur_r  <= cur_r[OW-1:0];
    end
    if (cmd.mul) begin
      pa_r  <= PW'(da_r) * PW'(ys_s);
      pb_r  <= PW'(xs_s) * PW'(db_r);
      pc_r  <= PW'(dc_r) * PW'(ys_s);
      pd_r  <= PW'(xs_s) * PW'(dd_r);
      pxy_r <= PW'(xs_s) * PW'(ys_s);
      xc_r  <= xm[QW-1:0];
      yc_r  <= cfg.print_height - ym[QW-1:0];
    end
    if (cmd.load1) begin
      out_tri.normal_x      <= scale(64'(pa_r));
      out_tri.normal_y      <= scale(-(64'(pxy_r)));
      out_tri.normal_z      <= scale(64'(pb_r));
      out_tri.first_x       <= xc_r;
      out_tri.second_x      <= xl;
      out_tri.shared_y      <= yu;
      out_tri.third_y       <= yc_r;
      out_tri.first_depth   <= o_up_r;
      out_tri.second_depth  <= o_ul_r;
      out_tri.third_depth   <= o_left_r;
      out_tri.last_of_pixel <= 1'b0;
    end else if (cmd.load2) begin
      out_tri.normal_x      <= scale(-(64'(pc_r)));
      out_tri.normal_y      <= scale(-(64'(pxy_r)));
      out_tri.normal_z      <= scale(-(64'(pd_r)));
      out_tri.first_x       <= xl;
      out_tri.second_x      <= xc_r;
      out_tri.shared_y      <= yc_r;
      out_tri.third_y       <= yu;
      out_tri.first_depth   <= o_left_r;
      out_tri.second_depth  <= o_cur_r;
      out_tri.third_depth   <= o_up_r;
      out_tri.last_of_pixel <= 1'b1;
    end
  end

  assign out_tri.valid = ov_r;
endmodule
`default_nettype wire

// File: rtl/heightmap_to_triangle_mesh_core.sv
// heightmap to triangle mesh core: top level
// depends on hmtm_pkg, hmtm_if, hmtm_regs, hmtm_ctrl, hmtm_dp and the assertion header
//
// usage:
//   in_pix takes rgb pixels in row-major order, valid/ready; out_tri gives two
//   triangles per pixel at column >= 1 and row >= 1, last_of_pixel marks the second.
//   border pixels (column 0 or row 0) only update the line buffer, neighbor depths and counters.
//   the apb port (psel..pready) sets frame size, steps, print height and gain;
//   write it only while the core is idle. pready is always high.
// timing:
//   one pixel at a time through a fixed sequence: accept, gain, depth, commit, and for
//   an interior pixel also mul and two emit states, each emit state waiting while the
//   output register is full and not taken; a border pixel returns to idle after commit.
//   the first triangle is loaded in the first emit state, the second is valid in the
//   cycle after the first transaction completes.
// reset:
//   rst_n (synchronous) clears the position counters, the neighbor depths, the
//   sequencer and the output valid; the line buffer keeps its contents.
// stall:
//   a stalled receiver holds the triangle in the output register and the
//   sequencer waits; the next pixel is taken once the second triangle is loaded.
`default_nettype none
`include "heightmap_to_triangle_mesh_core_assert.svh"
module heightmap_to_triangle_mesh_core #(
  parameter int unsigned MAX_WIDTH = hmtm_pkg::MAX_WIDTH_DEF,
  parameter int unsigned FRAC_BITS = hmtm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  hmtm_pix_if.sink                           in_pix,
  hmtm_tri_if.source                         out_tri,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hmtm_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [hmtm_pkg::DATA_W-1:0]   pwdata,
  output logic      [hmtm_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);
  hmtm_pkg::cfg_t     cfg;
  hmtm_pkg::dp_cmd_t  cmd;
  hmtm_pkg::dp_stat_t stat;
  logic               in_ready;

  assign in_pix.ready = in_ready;

  hmtm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hmtm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pix.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hmtm_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .cmd     (cmd),
    .stat    (stat),
    .red     (in_pix.red),
    .green   (in_pix.green),
    .blue    (in_pix.blue),
    .out_tri (out_tri)
  );

  // the sequencer never takes a second pixel right behind the first
  `HMTM_ASSERT_NEXT(a_one_pixel, in_pix.valid && in_pix.ready, !in_pix.ready, "back to back pixels")
  // the second triangle is loaded as soon as the first transaction completes
  `HMTM_ASSERT_NEXT(a_pair, out_tri.valid && out_tri.ready && !out_tri.last_of_pixel, out_tri.valid && out_tri.last_of_pixel, "second triangle missing")
  // no pixel is taken while a first triangle still waits
  `HMTM_ASSERT_NOW(a_no_take, out_tri.valid && !out_tri.last_of_pixel, !in_pix.ready, "pixel taken mid pair")
endmodule
`default_nettype wire
